### rtl/capacitive_slider_position_unit_macros.svh
// Assertion macros used by the slider position top level
`ifndef CAPACITIVE_SLIDER_POSITION_UNIT_MACROS_SVH
`define CAPACITIVE_SLIDER_POSITION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define CSP_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("slider position check failed");

// Next-cycle implication, sampled on clk, off during rst
`define CSP_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("slider position check failed");

`endif

### rtl/csp_pkg.sv
// Shared constants, types and state encodings of the slider position unit
`timescale 1ns / 1ps
package csp_pkg;

  localparam int NUM_PADS   = 4;
  localparam int COUNT_BITS = 16;
  localparam int LEVEL_W    = 9;
  localparam int THR_W      = 9;
  localparam int POS_W      = 7;
  localparam int NUM_W      = COUNT_BITS + 8;
  localparam int DEN_W      = (COUNT_BITS > LEVEL_W) ? COUNT_BITS : LEVEL_W;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int SEL_W      = $clog2(NUM_PADS);
  localparam int IN_TDATA_W = NUM_PADS * COUNT_BITS;
  localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(256);
  localparam logic [LEVEL_W-1:0] EDGE_LEVEL = LEVEL_W'(255);
  localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(236);

  typedef logic [LEVEL_W-1:0] lvl_t;

  typedef struct packed {
    logic             touched;
    logic [POS_W-1:0] position;
  } res_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_BUSY,
    TOP_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    MG_IDLE,
    MG_KICK,
    MG_WAIT
  } mg_state_t;

endpackage

### rtl/capacitive_slider_position_unit.sv
// Top level of the capacitive slider position unit
`timescale 1ns / 1ps
// Takes one scan of four 16-bit pad counts per request and returns one result:
// touched in m_tuser and a signed 7-bit position in sixteenths of a pad in
// m_tdata (0 when nothing is touched). Each pad has its own lane that tracks
// the running peak (reset to 1) and normalizes the count with a serial
// divider; a merge stage picks the touched pad and interpolates with two more
// serial dividers; the divide passes run one bit per cycle, and a scan with no
// touch skips the interpolation pass. The block is ready for the next request
// once the result enters the output register. One scan is processed at a time;
// a finished result waits in the output register while the next scan is taken.
// touch_threshold is written through cfg_we/cfg_wdata; it is to be written only
// while idle, which the block itself does not enforce; values above 256 act as
// 256.
module capacitive_slider_position_unit
  import csp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [THR_W-1:0]       cfg_wdata,   // touch_threshold
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,     // pad0_count, pad1_count, pad2_count, pad3_count
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,     // position, zero pad
  output logic                   m_tuser      // touched
);

  `include "capacitive_slider_position_unit_macros.svh"

  top_state_t state, state_next;

  logic [THR_W-1:0]    thr;
  logic                s_fire;
  logic [NUM_PADS-1:0] lane_done;
  lvl_t                level [NUM_PADS];
  logic                mg_done;
  res_t                mg_res;
  logic                out_free;
  logic                load;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  for (genvar i = 0; i < NUM_PADS; i++) begin : g_lane
    csp_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (s_fire),
      .count (s_tdata[i*COUNT_BITS +: COUNT_BITS]),
      .done  (lane_done[i]),
      .level (level[i])
    );
  end

  csp_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (&lane_done),
    .level (level),
    .thr   (thr),
    .done  (mg_done),
    .res   (mg_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    case (state)
      TOP_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = TOP_BUSY;
      end
      TOP_BUSY: begin
        if (mg_done) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = TOP_IDLE;
          end else begin
            state_next = TOP_HOLD;
          end
        end
      end
      TOP_HOLD: begin
        // merge result stays put until the output register drains
        if (out_free) begin
          load       = 1'b1;
          state_next = TOP_IDLE;
        end
      end
      default: state_next = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= mg_res.touched;
      m_tdata <= OUT_TDATA_W'(mg_res.position);
    end
  end

  `CSP_ASSERT_NXT(a_accept_busy, s_fire, state == TOP_BUSY)
  `CSP_ASSERT_IMP(a_merge_in_busy, mg_done, state == TOP_BUSY)
  `CSP_ASSERT_IMP(a_no_touch_zero, m_tvalid && !m_tuser, m_tdata == '0)

endmodule

### rtl/csp_div.sv
// Restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module csp_div
  import csp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [DCNT_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  rem_next;
  logic [NUM_W-1:0]  qr;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              qbit;

  always_comb begin
    rem_sh   = {rem, qr[NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    qbit     = (rem_sh >= {1'b0, den});
    rem_next = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DCNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= num;
      rem <= '0;
    end else if (cnt != '0) begin
      qr  <= {qr[NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quo = qr;

endmodule

### rtl/csp_lane.sv
// One pad lane: running peak and count*256/peak normalization
`timescale 1ns / 1ps
module csp_lane
  import csp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] count,
  output logic                  done,
  output lvl_t                  level
);

  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] peak_next;
  logic [NUM_W-1:0]      quo;

  assign peak_next = (count > peak) ? count : peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= COUNT_BITS'(1);
    end else if (start) begin
      peak <= peak_next;
    end
  end

  // divisor is read only after start, once peak already holds this scan's maximum
  csp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   ({count, 8'h00}),
    .den   (DEN_W'(peak)),
    .done  (done),
    .quo   (quo)
  );

  // count never exceeds peak, so the quotient stays within 0..256
  assign level = quo[LEVEL_W-1:0];

endmodule

### rtl/csp_merge.sv
// Merge stage: pick the touched pad and interpolate with its neighbors
`timescale 1ns / 1ps
module csp_merge
  import csp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lvl_t             level [NUM_PADS],
  input  logic [THR_W-1:0] thr,
  output logic             done,
  output res_t             res
);

  mg_state_t state, state_next;

  lvl_t             lv_ext [NUM_PADS+2];
  lvl_t             thr_c;
  lvl_t             best;
  logic             found;
  logic [SEL_W-1:0] sel;
  lvl_t             sel_left;
  lvl_t             sel_mid;
  lvl_t             sel_right;

  logic             hit;
  logic [SEL_W-1:0] sel_r;
  lvl_t             lvl_left;
  lvl_t             lvl_mid;
  lvl_t             lvl_right;

  logic             kick;
  logic             finish;
  logic             done_l;
  logic             done_r;
  logic [NUM_W-1:0] quo_l;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den;
  logic [POS_W-1:0] pos_calc;

  // least level strictly below the clipped threshold, first pad on ties
  always_comb begin
    lv_ext[0]          = EDGE_LEVEL;
    lv_ext[NUM_PADS+1] = EDGE_LEVEL;
    for (int i = 0; i < NUM_PADS; i++) begin
      lv_ext[i+1] = level[i];
    end
    thr_c     = (thr > THR_W'(FULL_LEVEL)) ? FULL_LEVEL : LEVEL_W'(thr);
    best      = thr_c;
    found     = 1'b0;
    sel       = '0;
    sel_left  = lv_ext[0];
    sel_mid   = lv_ext[1];
    sel_right = lv_ext[2];
    for (int i = 0; i < NUM_PADS; i++) begin
      if (lv_ext[i+1] < best) begin
        best      = lv_ext[i+1];
        found     = 1'b1;
        sel       = SEL_W'(i);
        sel_left  = lv_ext[i];
        sel_mid   = lv_ext[i+1];
        sel_right = lv_ext[i+2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_comb begin
    state_next = state;
    kick       = 1'b0;
    finish     = 1'b0;
    case (state)
      MG_IDLE: begin
        if (start) state_next = MG_KICK;
      end
      MG_KICK: begin
        if (hit) begin
          kick       = 1'b1;
          state_next = MG_WAIT;
        end else begin
          finish     = 1'b1;
          state_next = MG_IDLE;
        end
      end
      MG_WAIT: begin
        if (done_l) begin
          finish     = 1'b1;
          state_next = MG_IDLE;
        end
      end
      default: state_next = MG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && state == MG_IDLE) begin
      hit       <= found;
      sel_r     <= sel;
      lvl_left  <= sel_left;
      lvl_mid   <= sel_mid;
      lvl_right <= sel_right;
    end
  end

  assign den = DEN_W'(lvl_t'(FULL_LEVEL - lvl_mid));

  csp_div u_div_l (
    .clk   (clk),
    .rst   (rst),
    .start (kick),
    .num   (NUM_W'({lvl_t'(FULL_LEVEL - lvl_left), 3'b000})),
    .den   (den),
    .done  (done_l),
    .quo   (quo_l)
  );

  csp_div u_div_r (
    .clk   (clk),
    .rst   (rst),
    .start (kick),
    .num   (NUM_W'({lvl_t'(FULL_LEVEL - lvl_right), 3'b000})),
    .den   (den),
    .done  (done_r),
    .quo   (quo_r)
  );

  // both dividers run in lockstep; wrap the sum to the output width
  assign pos_calc = POS_W'({sel_r, 4'h0}) - quo_l[POS_W-1:0] + quo_r[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (finish) begin
      res.touched  <= hit;
      res.position <= (hit && (done_r || !done_r)) ? pos_calc : '0;
    end
  end

endmodule

### sim/tb_capacitive_slider_position_unit.sv
// Self-checking testbench for the capacitive slider position unit
`timescale 1ns / 1ps
module tb_capacitive_slider_position_unit;
  import csp_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_SCANS = 2000;

  // Slider predictor plus the queue of results still owed by the block
  class slider_position_tracker;
    logic [COUNT_BITS-1:0] peak [NUM_PADS];
    logic [THR_W-1:0]      threshold;
    res_t                  owed [$];
    int                    errors;
    int                    scans;
    int                    touches;
    int                    checked;

    function new();
      foreach (peak[i]) peak[i] = 1;
      threshold = THR_RESET;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Update the peaks with this scan and queue the position it yields
    function void note_scan(logic [IN_TDATA_W-1:0] word);
      int unsigned lvl [NUM_PADS+2];
      int unsigned cnt;
      int unsigned thr;
      int unsigned least;
      int unsigned div;
      int          sel;
      int          pos;
      res_t        r;
      lvl[0] = 255;
      lvl[NUM_PADS+1] = 255;
      for (int i = 0; i < NUM_PADS; i++) begin
        cnt = word[i*COUNT_BITS +: COUNT_BITS];
        if (cnt > peak[i]) peak[i] = cnt;
        lvl[i+1] = (cnt << 8) / peak[i];
      end
      thr = (threshold > 256) ? 256 : threshold;
      least = thr;
      sel = -1;
      for (int i = 1; i <= NUM_PADS; i++) begin
        if (lvl[i] < least) begin
          least = lvl[i];
          sel = i;
        end
      end
      if (sel < 0) begin
        r.touched = 1'b0;
        r.position = '0;
      end else begin
        div = 256 - lvl[sel];
        pos = (sel - 1) * 16;
        pos -= int'(((256 - lvl[sel-1]) << 3) / div);
        pos += int'(((256 - lvl[sel+1]) << 3) / div);
        r.touched = 1'b1;
        r.position = pos[POS_W-1:0];
        touches++;
      end
      owed.push_back(r);
      scans++;
    endfunction

    function void check_result(logic touched, logic [POS_W-1:0] position);
      res_t want;
      checked++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result touched=%0b position=%0d", $time, touched,
                 $signed(position));
        errors++;
        return;
      end
      want = owed.pop_front();
      if (touched !== want.touched) begin
        $display("%0t: touched mismatch, expected %0b actual %0b", $time, want.touched,
                 touched);
        errors++;
      end
      if (position !== want.position) begin
        $display("%0t: position mismatch, expected %0d actual %0d", $time,
                 $signed(want.position), $signed(position));
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [THR_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  slider_position_tracker sb = new();
  int cycles = 0;
  int thr_writes = 0;

  capacitive_slider_position_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_capacitive_slider_position_unit: done, errors");
      $finish;
    end
  end

  // Receiver: stall modes that change now and then, plus one long hold-off
  int rx_mode = 0;
  int rx_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[POS_W-1:0]);
      if (!hold_done && sb.scans >= 400) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 300);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 29) != 0);
        endcase
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_scan(int unsigned p0, int unsigned p1,
                                                      int unsigned p2, int unsigned p3);
    return {p3[COUNT_BITS-1:0], p2[COUNT_BITS-1:0], p1[COUNT_BITS-1:0], p0[COUNT_BITS-1:0]};
  endfunction

  // Build a realistic scan: one pad dips, neighbors may take any level, the rest sit near peak
  function automatic logic [IN_TDATA_W-1:0] shaped_scan();
    logic [IN_TDATA_W-1:0] word;
    int unsigned lvl;
    int unsigned pk;
    int          hit;
    hit = $urandom_range(0, NUM_PADS - 1);
    for (int i = 0; i < NUM_PADS; i++) begin
      pk = sb.peak[i];
      if (i == hit) lvl = $urandom_range(0, 255);
      else if (i == hit - 1 || i == hit + 1) lvl = $urandom_range(0, 256);
      else lvl = $urandom_range(224, 256);
      if ($urandom_range(0, 11) == 0) word[i*COUNT_BITS +: COUNT_BITS] =
          COUNT_BITS'($urandom_range(pk, 65535));
      else word[i*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'((pk * lvl) >> 8);
    end
    return word;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pick_scan();
    logic [IN_TDATA_W-1:0] word;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return shaped_scan();
    for (int i = 0; i < NUM_PADS; i++)
      word[i*COUNT_BITS +: COUNT_BITS] =
          COUNT_BITS'($urandom & ((32'h1 << $urandom_range(1, COUNT_BITS)) - 1));
    return word;
  endfunction

  task automatic send_scan(logic [IN_TDATA_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.note_scan(word);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the threshold once every owed result is back
  task automatic write_threshold(logic [THR_W-1:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = value;
    thr_writes++;
  endtask

  task automatic run_bursts(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_scan(pick_scan());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  logic [THR_W-1:0] phase_thr [6];

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset threshold: first scans see peaks of 1
    send_scan(pack_scan(0, 0, 0, 0));             // all touched, first pad wins
    send_scan(pack_scan(256, 256, 256, 256));     // raise peaks, no touch
    send_scan(pack_scan(256, 0, 0, 256));         // tie between middle pads
    send_scan(pack_scan(256, 256, 128, 256));

    // Full-scale threshold: reach both ends of the position range
    write_threshold(THR_W'(256));
    send_scan(pack_scan(255, 256, 256, 256));
    send_scan(pack_scan(256, 256, 256, 255));
    send_scan(pack_scan(256, 256, 256, 256));     // level equal to threshold
    send_scan(pack_scan(256, 255, 256, 256));

    // Threshold above 256 acts as 256
    write_threshold(THR_W'(511));
    send_scan(pack_scan(65535, 65535, 65535, 65535));
    send_scan(pack_scan(0, 0, 0, 0));
    send_scan(pack_scan(65535, 65535, 65535, 0));
    send_scan(pack_scan(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_scan(pack_scan(65535, 65280, 65535, 65535));

    // Zero threshold: nothing can count as touched
    write_threshold(THR_W'(0));
    send_scan(pack_scan(0, 0, 0, 0));
    send_scan(pack_scan(16'h5555, 0, 16'hAAAA, 65535));

    phase_thr[0] = THR_RESET;
    phase_thr[1] = THR_W'(511);
    phase_thr[2] = THR_W'(0);
    phase_thr[3] = THR_W'($urandom_range(100, 255));
    phase_thr[4] = THR_W'(256);
    phase_thr[5] = THR_W'($urandom_range(0, 511));
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      run_bursts(RANDOM_SCANS / 6);
    end

    wait_drained();
    $display("covered %0d scans (%0d touched) over %0d threshold writes", sb.scans,
             sb.touches, thr_writes);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_capacitive_slider_position_unit: done, clean");
    end else begin
      $display("tb_capacitive_slider_position_unit: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/csp_pkg.sv
rtl/csp_div.sv
rtl/csp_lane.sv
rtl/csp_merge.sv
rtl/capacitive_slider_position_unit.sv
sim/tb_capacitive_slider_position_unit.sv
